FILE: sv/pbs_pkg.sv
// Shared types and constants for the polyline Bezier smoother.
// Holds the controller states, the datapath command and status structs and the port widths.
// Depends on nothing; every other file imports it.
package pbs_pkg;

  localparam int DATA_W             = 32;
  localparam int TDATA_W            = 2 * DATA_W;
  localparam int DEF_SUBDIV_LEVELS  = 4;
  localparam int DEF_COORD_WIDTH    = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWO,
    S_TWO_END,
    S_LOAD1,
    S_LOAD2,
    S_CHK,
    S_RUN,
    S_TAIL
  } pbs_state_t;

  typedef enum logic [2:0] {
    EM_FIRST,
    EM_V,
    EM_MID_FV,
    EM_MID_FS,
    EM_CURVE
  } emit_sel_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_CURVE1,
    LD_CURVE2
  } load_sel_t;

  typedef struct packed {
    logic      accept;
    logic      start_line;
    logic      shift;
    logic      set_second;
    load_sel_t load;
    logic      s_raw;
    logic      e_raw;
    logic      init_run;
    logic      split;
    logic      pop;
    logic      emit;
    emit_sel_t emit_sel;
    logic      lor;
    logic      eol;
  } pbs_cmd_t;

  typedef struct packed {
    logic degen;
    logic level_zero;
    logic sp_zero;
    logic out_free;
  } pbs_status_t;

endpackage

FILE: sv/pbs_datapath.sv
// Datapath of the polyline Bezier smoother: vertex registers, curve registers,
// subdivision stack, the floor-midpoint arithmetic and the output register.
// Depends on pbs_pkg; driven by pbs_ctrl through pbs_cmd_t.
module pbs_datapath
  import pbs_pkg::*;
#(
  parameter int SUBDIV_LEVELS = DEF_SUBDIV_LEVELS,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbs_cmd_t           cmd_i,
  output pbs_status_t        status_o,
  input  logic [TDATA_W-1:0] in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,
  output logic [0:0]         out_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int LVL_W = $clog2(SUBDIV_LEVELS + 1);
  localparam int IDX_W = (SUBDIV_LEVELS > 1) ? $clog2(SUBDIV_LEVELS) : 1;

  function automatic logic signed [CW-1:0] mid_f(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [CW:0] sum;
    sum = {a[CW-1], a} + {b[CW-1], b};
    return sum[CW:1];
  endfunction

  logic signed [CW-1:0] in_x, in_y;
  logic signed [CW-1:0] v_x_r, v_y_r, first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [CW-1:0] older_x_r, older_y_r, prev_x_r, prev_y_r;
  logic signed [CW-1:0] s_x_r, s_y_r, c_x_r, c_y_r, e_x_r, e_y_r;
  logic signed [CW-1:0] stk_sx [SUBDIV_LEVELS];
  logic signed [CW-1:0] stk_sy [SUBDIV_LEVELS];
  logic signed [CW-1:0] stk_cx [SUBDIV_LEVELS];
  logic signed [CW-1:0] stk_cy [SUBDIV_LEVELS];
  logic signed [CW-1:0] stk_ex [SUBDIV_LEVELS];
  logic signed [CW-1:0] stk_ey [SUBDIV_LEVELS];
  logic [LVL_W-1:0]     stk_lvl [SUBDIV_LEVELS];
  logic [LVL_W-1:0]     sp_r, lvl_r, sp_m1;
  logic signed [CW-1:0] lc_x, lc_y, rc_x, rc_y, m_x, m_y;
  logic signed [CW-1:0] emit_x, emit_y;
  logic                 out_valid_r, out_last_r, out_eol_r;
  logic [DATA_W-1:0]    out_x_r, out_y_r;
  logic                 out_free;

  assign in_x  = in_tdata[CW-1:0];
  assign in_y  = in_tdata[DATA_W+CW-1:DATA_W];
  assign sp_m1 = sp_r - LVL_W'(1);

  assign lc_x = mid_f(s_x_r, c_x_r);
  assign lc_y = mid_f(s_y_r, c_y_r);
  assign rc_x = mid_f(c_x_r, e_x_r);
  assign rc_y = mid_f(c_y_r, e_y_r);
  assign m_x  = mid_f(lc_x, rc_x);
  assign m_y  = mid_f(lc_y, rc_y);

  assign out_free = !out_valid_r || out_tready;

  assign status_o.degen      = (s_x_r == c_x_r && s_y_r == c_y_r) ||
                               (c_x_r == e_x_r && c_y_r == e_y_r);
  assign status_o.level_zero = (lvl_r == '0);
  assign status_o.sp_zero    = (sp_r == '0);
  assign status_o.out_free   = out_free;

  always_comb begin
    case (cmd_i.emit_sel)
      EM_FIRST: begin
        emit_x = first_x_r;
        emit_y = first_y_r;
      end
      EM_V: begin
        emit_x = v_x_r;
        emit_y = v_y_r;
      end
      EM_MID_FV: begin
        emit_x = mid_f(first_x_r, v_x_r);
        emit_y = mid_f(first_y_r, v_y_r);
      end
      EM_MID_FS: begin
        emit_x = mid_f(first_x_r, second_x_r);
        emit_y = mid_f(first_y_r, second_y_r);
      end
      EM_CURVE: begin
        emit_x = e_x_r;
        emit_y = e_y_r;
      end
      default: begin
        emit_x = e_x_r;
        emit_y = e_y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      v_x_r <= in_x;
      v_y_r <= in_y;
    end
    if (cmd_i.start_line) begin
      first_x_r <= in_x;
      first_y_r <= in_y;
    end
    if (cmd_i.set_second) begin
      second_x_r <= v_x_r;
      second_y_r <= v_y_r;
    end
    if (cmd_i.start_line) begin
      prev_x_r <= in_x;
      prev_y_r <= in_y;
    end else if (cmd_i.shift) begin
      older_x_r <= prev_x_r;
      older_y_r <= prev_y_r;
      prev_x_r  <= v_x_r;
      prev_y_r  <= v_y_r;
    end
    case (cmd_i.load)
      LD_CURVE1: begin
        s_x_r <= cmd_i.s_raw ? older_x_r : mid_f(older_x_r, prev_x_r);
        s_y_r <= cmd_i.s_raw ? older_y_r : mid_f(older_y_r, prev_y_r);
        c_x_r <= prev_x_r;
        c_y_r <= prev_y_r;
        e_x_r <= cmd_i.e_raw ? v_x_r : mid_f(prev_x_r, v_x_r);
        e_y_r <= cmd_i.e_raw ? v_y_r : mid_f(prev_y_r, v_y_r);
      end
      LD_CURVE2: begin
        s_x_r <= mid_f(prev_x_r, v_x_r);
        s_y_r <= mid_f(prev_y_r, v_y_r);
        c_x_r <= v_x_r;
        c_y_r <= v_y_r;
        e_x_r <= mid_f(v_x_r, second_x_r);
        e_y_r <= mid_f(v_y_r, second_y_r);
      end
      LD_NONE: begin
        if (cmd_i.split) begin
          c_x_r <= lc_x;
          c_y_r <= lc_y;
          e_x_r <= m_x;
          e_y_r <= m_y;
        end else if (cmd_i.pop) begin
          s_x_r <= stk_sx[sp_m1[IDX_W-1:0]];
          s_y_r <= stk_sy[sp_m1[IDX_W-1:0]];
          c_x_r <= stk_cx[sp_m1[IDX_W-1:0]];
          c_y_r <= stk_cy[sp_m1[IDX_W-1:0]];
          e_x_r <= stk_ex[sp_m1[IDX_W-1:0]];
          e_y_r <= stk_ey[sp_m1[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.split) begin
      stk_sx[sp_r[IDX_W-1:0]]  <= m_x;
      stk_sy[sp_r[IDX_W-1:0]]  <= m_y;
      stk_cx[sp_r[IDX_W-1:0]]  <= rc_x;
      stk_cy[sp_r[IDX_W-1:0]]  <= rc_y;
      stk_ex[sp_r[IDX_W-1:0]]  <= e_x_r;
      stk_ey[sp_r[IDX_W-1:0]]  <= e_y_r;
      stk_lvl[sp_r[IDX_W-1:0]] <= lvl_r - LVL_W'(1);
    end
    if (cmd_i.emit) begin
      out_x_r    <= DATA_W'(emit_x);
      out_y_r    <= DATA_W'(emit_y);
      out_last_r <= cmd_i.lor;
      out_eol_r  <= cmd_i.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.init_run) begin
        sp_r  <= '0;
        lvl_r <= LVL_W'(SUBDIV_LEVELS);
      end else if (cmd_i.split) begin
        sp_r  <= sp_r + LVL_W'(1);
        lvl_r <= lvl_r - LVL_W'(1);
      end else if (cmd_i.pop) begin
        sp_r  <= sp_m1;
        lvl_r <= stk_lvl[sp_m1[IDX_W-1:0]];
      end
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eol_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || out_tready))
    else $error("result loaded while output register is held");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= LVL_W'(SUBDIV_LEVELS))
    else $error("subdivision stack overflow");
  a_split_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.split |-> (lvl_r != '0))
    else $error("split requested at leaf level");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pop |-> (sp_r != '0) && (lvl_r == '0))
    else $error("pop from empty stack or from an inner node");

endmodule

FILE: sv/pbs_ctrl.sv
// Controller of the polyline Bezier smoother: line bookkeeping and the
// sequencing of curve loads, subdivision steps and result transfers.
// Depends on pbs_pkg; commands pbs_datapath.
module pbs_ctrl
  import pbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tlast,
  input  logic [1:0]  in_tuser,
  input  pbs_status_t status_i,
  output pbs_cmd_t    cmd_o
);

  pbs_state_t st_r, st_nxt, after_curve;
  logic [1:0] count_r, count_nxt;
  logic       closed_r, closed_nxt, last_r, last_nxt, cur2_r, cur2_nxt;
  logic       in_acc, new_line, trailing;

  assign in_acc   = in_tvalid && in_tready;
  assign new_line = in_tuser[0] || (count_r == 2'd0);
  assign trailing = last_r && closed_r;

  always_comb begin
    if (cur2_r) begin
      after_curve = S_TAIL;
    end else if (trailing) begin
      after_curve = S_LOAD2;
    end else begin
      after_curve = S_IDLE;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    count_nxt  = count_r;
    closed_nxt = closed_r;
    last_nxt   = last_r;
    cur2_nxt   = cur2_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (new_line) begin
            closed_nxt = in_tuser[1];
            count_nxt  = in_tlast ? 2'd0 : 2'd1;
          end else begin
            last_nxt = in_tlast;
            st_nxt   = (count_r == 2'd1) ? S_TWO : S_LOAD1;
          end
        end
      end
      S_TWO: begin
        if (status_i.out_free) begin
          if (last_r) begin
            st_nxt = S_TWO_END;
          end else begin
            count_nxt = 2'd2;
            st_nxt    = S_IDLE;
          end
        end
      end
      S_TWO_END: begin
        if (status_i.out_free) begin
          count_nxt = 2'd0;
          st_nxt    = S_IDLE;
        end
      end
      S_LOAD1: begin
        cur2_nxt  = 1'b0;
        count_nxt = last_r ? 2'd0 : 2'd3;
        st_nxt    = S_CHK;
      end
      S_LOAD2: begin
        cur2_nxt = 1'b1;
        st_nxt   = S_CHK;
      end
      S_CHK: begin
        st_nxt = status_i.degen ? after_curve : S_RUN;
      end
      S_RUN: begin
        if (status_i.level_zero && status_i.out_free && status_i.sp_zero) begin
          st_nxt = after_curve;
        end
      end
      S_TAIL: begin
        if (status_i.out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd_o     = '0;
    cmd_o.load     = LD_NONE;
    cmd_o.emit_sel = EM_CURVE;
    case (st_r)
      S_IDLE: begin
        in_tready        = 1'b1;
        cmd_o.accept     = in_acc;
        cmd_o.start_line = in_acc && new_line;
      end
      S_TWO: begin
        cmd_o.emit       = status_i.out_free;
        cmd_o.set_second = status_i.out_free;
        if (last_r) begin
          cmd_o.emit_sel = EM_FIRST;
        end else begin
          cmd_o.emit_sel = closed_r ? EM_MID_FV : EM_FIRST;
          cmd_o.lor      = 1'b1;
          cmd_o.shift    = status_i.out_free;
        end
      end
      S_TWO_END: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.emit_sel = EM_V;
        cmd_o.lor      = 1'b1;
        cmd_o.eol      = 1'b1;
      end
      S_LOAD1: begin
        cmd_o.load  = LD_CURVE1;
        cmd_o.s_raw = !closed_r && (count_r == 2'd2);
        cmd_o.e_raw = !closed_r && last_r;
        cmd_o.shift = !last_r;
      end
      S_LOAD2: begin
        cmd_o.load = LD_CURVE2;
      end
      S_CHK: begin
        cmd_o.init_run = !status_i.degen;
      end
      S_RUN: begin
        if (!status_i.level_zero) begin
          cmd_o.split = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.pop  = !status_i.sp_zero;
          cmd_o.lor  = status_i.sp_zero && !trailing;
          cmd_o.eol  = status_i.sp_zero && !trailing && last_r;
        end
      end
      S_TAIL: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.emit_sel = EM_MID_FS;
        cmd_o.lor      = 1'b1;
        cmd_o.eol      = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      count_r  <= 2'd0;
      closed_r <= 1'b0;
      last_r   <= 1'b0;
      cur2_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      count_r  <= count_nxt;
      closed_r <= closed_nxt;
      last_r   <= last_nxt;
      cur2_r   <= cur2_nxt;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !new_line |=> (st_r == S_TWO || st_r == S_LOAD1))
    else $error("accepted vertex did not start its work");
  a_tail_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TAIL || st_r == S_LOAD2) |-> (last_r && closed_r))
    else $error("closing work entered for a line that is not closed and ending");
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.eol && cmd_o.emit) |=> (count_r == 2'd0))
    else $error("end of line sent while the line stays open");

endmodule

FILE: sv/polyline_bezier_smoother_unit.sv
// Polyline smoother that replaces each interior vertex by a subdivided quadratic Bezier.
// Top level: joins pbs_ctrl and pbs_datapath. Depends on pbs_pkg.
//
// Usage: vertices enter on the in_ channel; in_tdata carries x (bits 31:0) and y (63:32),
// in_tlast marks the line's final vertex, in_tuser[0] starts a new line and in_tuser[1]
// says the line is closed. Smoothed points leave on the out_ channel with x and y packed
// the same way, out_tlast on the last point caused by a vertex and out_tuser[0] on the
// final point of the line.
// Sequencing: a vertex is accepted in the idle state only, one at a time. A line's first vertex
// is only stored; a second vertex sends one point, two when it ends the line. An interior vertex
// is accepted, its curve loaded and tested, then one subdivision step or, while the output
// register is free, one point transfer is made per cycle. A curve with a repeated control
// point is not subdivided and sends no points.
// The closing vertex of a closed line runs two curves and one extra point.
// The first point appears in the cycle after it is formed.
// Reset clears the line state and empties the output register. When the receiver stalls,
// the point waits in the output register and no further point is loaded until it is taken.
module polyline_bezier_smoother_unit
  import pbs_pkg::*;
#(
  parameter int SUBDIV_LEVELS = DEF_SUBDIV_LEVELS,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // x, y
  input  logic               in_tlast,
  input  logic [1:0]         in_tuser,   // first_point, closed
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // out_x, out_y
  output logic               out_tlast,
  output logic [0:0]         out_tuser   // end_of_line
);

  pbs_cmd_t    cmd;
  pbs_status_t status;

  pbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pbs_datapath #(
    .SUBDIV_LEVELS (SUBDIV_LEVELS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
